/* design/pqt_pkg.sv */
// ----------------------------------------------------------------------------
// pqt_pkg: shared types and constants of the priority queue table
// Holds the table size, the operation and status codes, and the sequencer
// states used by the top level.
// ----------------------------------------------------------------------------
package pqt_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned MATCH_W = 5;
  localparam int unsigned ENTRY_W = KEY_W + PRIO_W;

  // Operation requested by an input request.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_CHANGE = 2'd3
  } pqt_mode_e;

  // Result status.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } pqt_status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } pqt_state_e;

endpackage

/* design/pqt_ram.sv */
// ----------------------------------------------------------------------------
// pqt_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pqt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/priority_queue_table.sv */
// Requests: one at a time; the next request is taken only after the result is
//   loaded and the sequencer is back in its idle state.
// Reset: asynchronous, active low; clears the entry count and control state.
//   The entry RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// priority_queue_table: bounded priority queue kept as a table
// Entries stay in insertion order in a RAM. A small sequencer walks the RAM
// through one shared compare unit to find the highest priority, count a
// priority or look up a key, and then shifts entries down after a removal.
// ----------------------------------------------------------------------------
module priority_queue_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input request channel.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,  // [31:0] item_key, [63:32] prio_value
  input  pqt_pkg::pqt_mode_e  s_axis_tuser,  // [1:0] mode
  // Result channel.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [71:0]         m_axis_tdata,  // [31:0] key_out, [63:32] prio_out,
                                             // [68:64] match_count, [69] is_empty,
                                             // [71:70] zero
  output pqt_pkg::pqt_status_e m_axis_tuser  // [1:0] status
);

  import pqt_pkg::*;

  // Sequencer and working state.
  pqt_state_e             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   pv_q, pv_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  pqt_mode_e              mode_q;
  logic [KEY_W-1:0]       key_q;
  logic [PRIO_W-1:0]      prio_q;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [KEY_W-1:0]       best_key_q, best_key_d;
  logic [PRIO_W-1:0]      best_prio_q, best_prio_d;
  pqt_status_e            res_status_q, res_status_d;
  logic [KEY_W-1:0]       res_key_q, res_key_d;
  logic [PRIO_W-1:0]      res_prio_q, res_prio_d;
  logic [MATCH_W-1:0]     match_q, match_d;

  // Output register.
  logic                   m_valid_q, m_valid_d;
  pqt_status_e            out_status_q;
  logic [KEY_W-1:0]       out_key_q;
  logic [PRIO_W-1:0]      out_prio_q;
  logic [MATCH_W-1:0]     out_match_q;
  logic                   out_empty_q;
  logic                   out_load;

  // RAM ports.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [PRIO_W-1:0]      rd_prio;

  // Shared compare unit.
  logic [31:0]            cmp_a, cmp_b;
  logic                   cmp_eq, cmp_gt;

  logic                   in_accept;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign rd_key  = ram_rdata[KEY_W-1:0];
  assign rd_prio = ram_rdata[ENTRY_W-1:KEY_W];

  // Entry storage: key in the low half, priority in the high half.
  pqt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Compares the read entry with the operand, or on remove with the best priority.
  always_comb begin
    unique case (mode_q)
      MODE_REMOVE: begin
        cmp_a = rd_prio;
        cmp_b = best_prio_q;
      end
      MODE_CHANGE: begin
        cmp_a = rd_key;
        cmp_b = key_q;
      end
      default: begin
        cmp_a = rd_prio;
        cmp_b = prio_q;
      end
    endcase
  end

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_gt = ($signed(cmp_a) > $signed(cmp_b));

  // Next state and datapath control of the sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    best_prio_d  = best_prio_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_prio_d   = res_prio_q;
    match_d      = match_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_wdata    = {prio_q, key_q};
    ram_raddr    = idx_q[IDX_W-1:0];
    out_load     = 1'b0;
    m_valid_d    = m_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_START;
        end
      end

      ST_START: begin
        res_status_d = STATUS_OK;
        res_key_d    = '0;
        res_prio_d   = '0;
        match_d      = '0;
        idx_d        = '0;
        unique case (mode_q)
          MODE_INSERT: begin
            if (count_q == CNT_W'(CAPACITY)) begin
              res_status_d = STATUS_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
            state_d = ST_DONE;
          end
          MODE_REMOVE: begin
            if (count_q == '0) begin
              res_status_d = STATUS_MISS;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          MODE_COUNT: begin
            state_d = ST_SCAN;
          end
          default: begin
            res_status_d = STATUS_MISS;
            state_d      = ST_SCAN;
          end
        endcase
      end

      ST_SCAN: begin
        // Issue one read a cycle while entries remain.
        if (idx_q < count_q) begin
          pv_d   = 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
        end
        // Judge the entry read in the previous cycle.
        if (pv_q) begin
          unique case (mode_q)
            MODE_REMOVE: begin
              if (pidx_q == '0 || cmp_gt) begin
                best_idx_d  = pidx_q;
                best_key_d  = rd_key;
                best_prio_d = rd_prio;
              end
            end
            MODE_CHANGE: begin
              if (cmp_eq) begin
                ram_we       = 1'b1;
                ram_waddr    = pidx_q;
                ram_wdata    = {prio_q, rd_key};
                res_status_d = STATUS_OK;
                res_prio_d   = rd_prio;
                pv_d         = 1'b0;
                state_d      = ST_DONE;
              end
            end
            default: begin
              if (cmp_eq && !(&match_q)) begin
                match_d = match_q + MATCH_W'(1);
              end
            end
          endcase
        end
        // Scan finished with no early stop.
        if (idx_q == count_q && !pv_q) begin
          if (mode_q == MODE_REMOVE) begin
            res_key_d  = best_key_q;
            res_prio_d = best_prio_q;
            idx_d      = CNT_W'(best_idx_q) + CNT_W'(1);
            state_d    = ST_SHIFT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_SHIFT: begin
        // Read entry i and write it back at i - 1 in the next cycle.
        if (idx_q < count_q) begin
          pv_d   = 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
        end
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_q == count_q && !pv_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      pv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      pv_q      <= pv_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      prio_q <= s_axis_tdata[63:32];
    end
    pidx_q       <= pidx_d;
    best_idx_q   <= best_idx_d;
    best_key_q   <= best_key_d;
    best_prio_q  <= best_prio_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_prio_q   <= res_prio_d;
    match_q      <= match_d;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_prio_q   <= res_prio_q;
      out_match_q  <= match_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_empty_q, out_match_q, out_prio_q, out_key_q};

`ifndef SYNTH
  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The entry count moves by at most one per request, only in start or shift state.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == ST_START ||
                                     $past(state_q) == ST_SHIFT))
    else $error("entry count changed outside insert or shift");

  // The RAM is written only while a request is being worked on.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_START || state_q == ST_SCAN || state_q == ST_SHIFT))
    else $error("entry RAM written while idle");

  // A new result appears only when the sequencer leaves its done state.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside done state");

  // An accepted request always starts the sequencer.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_START))
    else $error("accepted request did not start the sequencer");
`endif

endmodule

/* tb/priority_queue_table_tb.sv */
// ----------------------------------------------------------------------------
// priority_queue_table_tb: self-checking bench for the priority queue table
// Sends insert, remove, count and change requests over the input stream and
// checks every result against a behavioral copy of the queue kept in the
// bench or against one typed by hand. A short directed table covers the
// empty and full queue, the field extremes and priority ties. Random traffic
// follows, in phases with different sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module priority_queue_table_tb;
  import pqt_pkg::*;

  // Result fields as they leave the block.
  typedef struct packed {
    pqt_status_e          status;
    logic [KEY_W-1:0]     key_out;
    logic [PRIO_W-1:0]    prio_out;
    logic [MATCH_W-1:0]   match_count;
    logic                 is_empty;
  } pq_result_t;

  // One row of the directed table; typed_ok marks a result written in by hand.
  typedef struct packed {
    pqt_mode_e            mode;
    logic [KEY_W-1:0]     key;
    logic [PRIO_W-1:0]    prio;
    logic [4:0]           reps;
    logic                 typed_ok;
    pq_result_t           typed_res;
  } stim_row_t;

  localparam pq_result_t NO_CHECK = '{STATUS_OK, 32'h0, 32'h0, 5'd0, 1'b0};
  localparam int ROWS        = 13;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 60;
  localparam int IDLE_LIMIT  = 3000;

  localparam stim_row_t DIRECTED [ROWS] = '{
    // Empty queue right after reset.
    '{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b1,
      '{STATUS_MISS, 32'h0, 32'h0, 5'd0, 1'b1}},
    '{MODE_CHANGE, 32'h0000_0001, 32'h0000_0007, 5'd1, 1'b1,
      '{STATUS_MISS, 32'h0, 32'h0, 5'd0, 1'b1}},
    '{MODE_COUNT,  32'h0000_0000, 32'h0000_0000, 5'd1, 1'b1,
      '{STATUS_OK, 32'h0, 32'h0, 5'd0, 1'b1}},
    // Field extremes, with a tie on the highest priority.
    '{MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd1, 1'b1,
      '{STATUS_OK, 32'h0, 32'h0, 5'd0, 1'b0}},
    '{MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd1, 1'b1,
      '{STATUS_OK, 32'h0, 32'h0, 5'd0, 1'b0}},
    '{MODE_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b1,
      '{STATUS_OK, 32'h0, 32'h0, 5'd0, 1'b0}},
    '{MODE_COUNT,  32'h0000_0000, 32'h7FFF_FFFF, 5'd1, 1'b0, NO_CHECK},
    '{MODE_CHANGE, 32'hFFFF_FFFF, 32'h0000_0000, 5'd1, 1'b0, NO_CHECK},
    // Absent key on a non-empty queue.
    '{MODE_CHANGE, 32'h0000_002A, 32'h1234_5678, 5'd1, 1'b1,
      '{STATUS_MISS, 32'h0, 32'h0, 5'd0, 1'b0}},
    '{MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, NO_CHECK},
    // Fill the queue, then insert once more into the full queue.
    '{MODE_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 5'd14, 1'b0, NO_CHECK},
    '{MODE_INSERT, 32'h0000_0001, 32'h0000_0001, 5'd1, 1'b1,
      '{STATUS_FULL, 32'h0, 32'h0, 5'd0, 1'b0}},
    '{MODE_COUNT,  32'h0000_0000, 32'hAAAA_AAAA, 5'd1, 1'b0, NO_CHECK}
  };

  localparam int SEND_IDLE  [PHASES] = '{0, 57, 0, 27};
  localparam int RECV_STALL [PHASES] = '{0, 0, 57, 27};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;
  pqt_mode_e            s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [71:0]          m_axis_tdata;
  pqt_status_e          m_axis_tuser;

  // Bench copy of the queue contents.
  logic [KEY_W-1:0]     pq_key  [CAPACITY];
  logic [PRIO_W-1:0]    pq_prio [CAPACITY];
  int                   pq_fill;

  pq_result_t           expected_results [$];
  int                   error_count  = 0;
  int                   result_index = 0;
  int                   idle_cycles  = 0;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  bit                   hold_start   = 1'b0;
  int                   hold_left;

  priority_queue_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one request to the bench queue and return the result it gives.
  function automatic pq_result_t predict_request(pqt_mode_e mode, logic [KEY_W-1:0] key,
                                                 logic [PRIO_W-1:0] prio);
    pq_result_t res;
    int         best;
    int         i;
    bit         found;
    res   = NO_CHECK;
    found = 1'b0;
    case (mode)
      MODE_INSERT: begin
        if (pq_fill >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          pq_key[pq_fill]  = key;
          pq_prio[pq_fill] = prio;
          pq_fill++;
        end
      end
      MODE_REMOVE: begin
        if (pq_fill == 0) begin
          res.status = STATUS_MISS;
        end else begin
          // Strict compare keeps the earliest entry on a tie.
          best = 0;
          for (i = 1; i < pq_fill; i++)
            if ($signed(pq_prio[i]) > $signed(pq_prio[best])) best = i;
          res.key_out  = pq_key[best];
          res.prio_out = pq_prio[best];
          for (i = best; i < pq_fill - 1; i++) begin
            pq_key[i]  = pq_key[i+1];
            pq_prio[i] = pq_prio[i+1];
          end
          pq_fill--;
        end
      end
      MODE_COUNT: begin
        for (i = 0; i < pq_fill; i++)
          if (pq_prio[i] == prio && res.match_count != 5'd31)
            res.match_count = res.match_count + 5'd1;
      end
      default: begin
        res.status = STATUS_MISS;
        for (i = 0; i < pq_fill; i++) begin
          if (!found && pq_key[i] == key) begin
            res.prio_out = pq_prio[i];
            pq_prio[i]   = prio;
            res.status   = STATUS_OK;
            found        = 1'b1;
          end
        end
      end
    endcase
    res.is_empty = (pq_fill == 0);
    return res;
  endfunction

  // Priorities lean toward a few small values so that ties and counts happen.
  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 40) return PRIO_W'($signed($urandom_range(6)) - 3);
    if (r < 45) return 32'h7FFF_FFFF;
    if (r < 50) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 40) return KEY_W'($urandom_range(7));
    return $urandom;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h, expected %h", result_index, field, got, want);
    error_count++;
  endtask

  // Offer one request; the expectation is recorded at the accepting edge.
  task automatic push_request(pqt_mode_e mode, logic [KEY_W-1:0] key,
                              logic [PRIO_W-1:0] prio, bit use_typed, pq_result_t typed);
    pq_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, key};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_request(mode, key, prio);
    expected_results.push_back(use_typed ? typed : predicted);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_start && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
      end else begin
        pq_result_t want;
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.key_out)
          report_mismatch("key_out", m_axis_tdata[31:0], want.key_out);
        if (m_axis_tdata[63:32] !== want.prio_out)
          report_mismatch("prio_out", m_axis_tdata[63:32], want.prio_out);
        if (m_axis_tdata[68:64] !== want.match_count)
          report_mismatch("match_count", 32'(m_axis_tdata[68:64]), 32'(want.match_count));
        if (m_axis_tdata[69] !== want.is_empty)
          report_mismatch("is_empty", 32'(m_axis_tdata[69]), 32'(want.is_empty));
        if (m_axis_tdata[71:70] !== 2'b00)
          report_mismatch("padding", 32'(m_axis_tdata[71:70]), 32'h0);
      end
      result_index++;
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int        row;
    int        k;
    int        phase;
    int        n;
    int        r;
    bit        fill_bias;
    pqt_mode_e mode;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = MODE_INSERT;
    pq_fill        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (row = 0; row < ROWS; row++)
      for (k = 0; k < DIRECTED[row].reps; k++)
        push_request(DIRECTED[row].mode, DIRECTED[row].key, DIRECTED[row].prio,
                     DIRECTED[row].typed_ok, DIRECTED[row].typed_res);
    drain_results();

    // Random traffic; the mix swings between filling and draining the queue.
    for (phase = 0; phase < PHASES; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 20) hold_start = 1'b1;
        fill_bias = ((n / 30) % 2) == 0;
        r = $urandom_range(99);
        if ($urandom_range(99) < 10) begin
          // Noise: every field fully random.
          mode = pqt_mode_e'($urandom_range(3));
          key  = $urandom;
          prio = $urandom;
        end else begin
          if (r < (fill_bias ? 50 : 25))      mode = MODE_INSERT;
          else if (r < (fill_bias ? 70 : 65)) mode = MODE_REMOVE;
          else if (r < 82)                    mode = MODE_COUNT;
          else                                mode = MODE_CHANGE;
          key  = pick_key();
          prio = pick_prio();
          if (pq_fill > 0 && mode == MODE_CHANGE && $urandom_range(99) < 60)
            key = pq_key[$urandom_range(pq_fill - 1)];
          if (pq_fill > 0 && mode == MODE_COUNT && $urandom_range(99) < 50)
            prio = pq_prio[$urandom_range(pq_fill - 1)];
        end
        push_request(mode, key, prio, 1'b0, NO_CHECK);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* priority_queue_table.f */
design/pqt_pkg.sv
design/pqt_ram.sv
design/priority_queue_table.sv
tb/priority_queue_table_tb.sv
